[rtl/artt_pkg.sv]
// Shared types and constants for the address region translation table.
package artt_pkg;

	localparam int unsigned REGION_ENTRIES_DEF = 16;

	localparam int unsigned SLOT_W = 16;
	localparam int unsigned ADDR_W = 64;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_UNMAP = 2'd1,
		OP_XLATE = 2'd2
	} artt_op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_UNKNOWN_SLOT = 2'd1,
		ST_NO_MATCH     = 2'd2,
		ST_FULL         = 2'd3
	} artt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_RESOLVE,
		S_FINISH
	} artt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic match;
		logic resolve;
		logic finish;
	} artt_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} artt_stat_t;

endpackage

[rtl/artt_ctrl.sv]
// Controller state machine that steps one item through match, resolve and finish.
module artt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  artt_pkg::artt_stat_t  stat,
	output artt_pkg::artt_ctrl_t  ctrl
);
	import artt_pkg::*;

	artt_state_t state_q;
	artt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.capture = 1'b1;
					state_d      = S_MATCH;
				end
			end
			S_MATCH: begin
				ctrl.match = 1'b1;
				state_d    = S_RESOLVE;
			end
			S_RESOLVE: begin
				ctrl.resolve = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				// Hold here while the previous result has not been taken.
				if (stat.out_free) begin
					ctrl.finish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/artt_datapath.sv]
// Region table, per-entry comparators, priority select and the output register.
module artt_datapath #(
	parameter int unsigned Entries = artt_pkg::REGION_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  artt_pkg::artt_ctrl_t        ctrl,
	output artt_pkg::artt_stat_t        stat,
	input  logic [1:0]                  cmd,
	input  logic [artt_pkg::SLOT_W-1:0] slot_id,
	input  logic [artt_pkg::ADDR_W-1:0] guest_address,
	input  logic [artt_pkg::ADDR_W-1:0] region_length,
	input  logic [artt_pkg::ADDR_W-1:0] host_base,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [artt_pkg::ADDR_W-1:0] host_address,
	output logic [artt_pkg::ADDR_W-1:0] remaining_bytes
);
	import artt_pkg::*;

	// Captured item.
	logic [1:0]        cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] len_q;
	logic [ADDR_W-1:0] host_q;

	// Region table, position 0 is the newest entry.
	logic [Entries-1:0] ent_valid_q;
	logic [SLOT_W-1:0]  ent_slot_q [Entries];
	logic [ADDR_W-1:0]  ent_base_q [Entries];
	logic [ADDR_W-1:0]  ent_len_q  [Entries];
	logic [ADDR_W-1:0]  ent_host_q [Entries];

	logic [Entries-1:0] hit_vec;
	logic [Entries-1:0] hit_q;
	logic [Entries-1:0] prior;
	logic [Entries-1:0] first;
	logic [Entries-1:0] at_or_after;
	logic               any_hit;
	logic               map_go;
	logic               unmap_go;

	logic [ADDR_W-1:0]  sel_base;
	logic [ADDR_W-1:0]  sel_len;
	logic [ADDR_W-1:0]  sel_host;
	artt_status_t       res_status;

	// Resolved lookup.
	artt_status_t       status_q;
	logic               xl_ok_q;
	logic [ADDR_W-1:0]  sel_len_q;
	logic [ADDR_W-1:0]  sel_host_q;
	logic [ADDR_W-1:0]  off_q;

	// Output register.
	logic               out_valid_q;
	artt_status_t       out_status_q;
	logic [ADDR_W-1:0]  out_host_q;
	logic [ADDR_W-1:0]  out_rem_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q  <= cmd;
			slot_q <= slot_id;
			addr_q <= guest_address;
			len_q  <= region_length;
			host_q <= host_base;
		end
	end

	// One comparator set per entry; the end of a region wraps modulo 2^64.
	always_comb begin
		for (int i = 0; i < Entries; i++) begin
			if (cmd_q == OP_UNMAP) begin
				hit_vec[i] = ent_valid_q[i] && (ent_slot_q[i] == slot_q);
			end else begin
				hit_vec[i] = ent_valid_q[i] && (ent_base_q[i] <= addr_q) &&
					(addr_q < ent_base_q[i] + ent_len_q[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.match) begin
			hit_q <= hit_vec;
		end
	end

	// The newest hit wins; everything from it onward moves up on an unmap.
	always_comb begin
		prior[0] = 1'b0;
		for (int i = 1; i < Entries; i++) begin
			prior[i] = prior[i-1] | hit_q[i-1];
		end
		first       = hit_q & ~prior;
		at_or_after = hit_q | prior;
		any_hit     = |hit_q;
	end

	always_comb begin
		sel_base = '0;
		sel_len  = '0;
		sel_host = '0;
		for (int i = 0; i < Entries; i++) begin
			sel_base = sel_base | ({ADDR_W{first[i]}} & ent_base_q[i]);
			sel_len  = sel_len  | ({ADDR_W{first[i]}} & ent_len_q[i]);
			sel_host = sel_host | ({ADDR_W{first[i]}} & ent_host_q[i]);
		end
	end

	always_comb begin
		case (cmd_q)
			OP_MAP:   res_status = ent_valid_q[Entries-1] ? ST_FULL : ST_OK;
			OP_UNMAP: res_status = any_hit ? ST_OK : ST_UNKNOWN_SLOT;
			OP_XLATE: res_status = any_hit ? ST_OK : ST_NO_MATCH;
			default:  res_status = ST_OK;
		endcase
	end

	assign map_go   = ctrl.resolve && (cmd_q == OP_MAP) && !ent_valid_q[Entries-1];
	assign unmap_go = ctrl.resolve && (cmd_q == OP_UNMAP) && any_hit;

	for (genvar g = 0; g < Entries; g++) begin : g_ent
		logic [SLOT_W-1:0] up_slot;
		logic [ADDR_W-1:0] up_base;
		logic [ADDR_W-1:0] up_len;
		logic [ADDR_W-1:0] up_host;
		logic              up_valid;
		logic [SLOT_W-1:0] dn_slot;
		logic [ADDR_W-1:0] dn_base;
		logic [ADDR_W-1:0] dn_len;
		logic [ADDR_W-1:0] dn_host;
		logic              dn_valid;

		if (g == 0) begin : g_head
			assign up_slot  = slot_q;
			assign up_base  = addr_q;
			assign up_len   = len_q;
			assign up_host  = host_q;
			assign up_valid = 1'b1;
		end else begin : g_body
			assign up_slot  = ent_slot_q[g-1];
			assign up_base  = ent_base_q[g-1];
			assign up_len   = ent_len_q[g-1];
			assign up_host  = ent_host_q[g-1];
			assign up_valid = ent_valid_q[g-1];
		end

		if (g < Entries - 1) begin : g_next
			assign dn_slot  = ent_slot_q[g+1];
			assign dn_base  = ent_base_q[g+1];
			assign dn_len   = ent_len_q[g+1];
			assign dn_host  = ent_host_q[g+1];
			assign dn_valid = ent_valid_q[g+1];
		end else begin : g_tail
			// The oldest position is left invalid; its payload does not matter.
			assign dn_slot  = ent_slot_q[g];
			assign dn_base  = ent_base_q[g];
			assign dn_len   = ent_len_q[g];
			assign dn_host  = ent_host_q[g];
			assign dn_valid = 1'b0;
		end

		always_ff @(posedge clk) begin
			if (map_go) begin
				ent_slot_q[g] <= up_slot;
				ent_base_q[g] <= up_base;
				ent_len_q[g]  <= up_len;
				ent_host_q[g] <= up_host;
			end else if (unmap_go && at_or_after[g]) begin
				ent_slot_q[g] <= dn_slot;
				ent_base_q[g] <= dn_base;
				ent_len_q[g]  <= dn_len;
				ent_host_q[g] <= dn_host;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ent_valid_q[g] <= 1'b0;
			end else if (map_go) begin
				ent_valid_q[g] <= up_valid;
			end else if (unmap_go && at_or_after[g]) begin
				ent_valid_q[g] <= dn_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.resolve) begin
			status_q   <= res_status;
			xl_ok_q    <= (cmd_q == OP_XLATE) && any_hit;
			sel_len_q  <= sel_len;
			sel_host_q <= sel_host;
			off_q      <= addr_q - sel_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_status_q <= status_q;
			out_host_q   <= xl_ok_q ? (sel_host_q + off_q) : '0;
			out_rem_q    <= xl_ok_q ? (sel_len_q - off_q) : '0;
		end
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign host_address    = out_host_q;
	assign remaining_bytes = out_rem_q;

endmodule

[rtl/address_region_translation_table.sv]
// Top level of the address region translation table.
//
//   channel   direction   handshake            payload
//   in        to block    in_valid/in_ready    cmd, slot_id, guest_address,
//                                              region_length, host_base
//   out       from block  out_valid/out_ready  status, host_address, remaining_bytes
//
// Each item steps through accept, compare against all entries at once,
// pick the newest hit and update the table, then form the result.
// A new item is accepted the cycle after the previous result is loaded.
// Reset empties the table; no clearing pass is needed.
// A result waiting in the output register holds the next item in its last
// step until out_ready frees the register.
module address_region_translation_table #(
	parameter int unsigned REGION_ENTRIES = artt_pkg::REGION_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  cmd,
	input  logic [artt_pkg::SLOT_W-1:0] slot_id,
	input  logic [artt_pkg::ADDR_W-1:0] guest_address,
	input  logic [artt_pkg::ADDR_W-1:0] region_length,
	input  logic [artt_pkg::ADDR_W-1:0] host_base,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [artt_pkg::ADDR_W-1:0] host_address,
	output logic [artt_pkg::ADDR_W-1:0] remaining_bytes
);
	import artt_pkg::*;

	artt_ctrl_t ctrl;
	artt_stat_t stat;

	artt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	artt_datapath #(
		.Entries (REGION_ENTRIES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.stat            (stat),
		.cmd             (cmd),
		.slot_id         (slot_id),
		.guest_address   (guest_address),
		.region_length   (region_length),
		.host_base       (host_base),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.host_address    (host_address),
		.remaining_bytes (remaining_bytes)
	);

endmodule
